// ===== hdl/pab_pkg.sv =====
// Shared constants and stage payload types for the premultiplied alpha blend.
// No dependencies; every other file in hdl/ refers to this package.
package pab_pkg;

  localparam int unsigned ChanW           = 8;
  localparam int unsigned NumChan         = 3;
  localparam int unsigned NumW            = 2 * ChanW;
  localparam int unsigned DivStepsPerStg  = 4;
  localparam int unsigned DivStages       = NumW / DivStepsPerStg;
  localparam int unsigned NumStg          = DivStages + 2;

  localparam logic [ChanW-1:0] FullScale  = 8'hFF;
  localparam logic [ChanW-1:0] MinAlpha   = 8'h01;

  // channel order: 0 blue, 1 green, 2 red
  typedef logic [NumChan-1:0][ChanW-1:0] chan_vec_t;

  typedef struct packed {
    chan_vec_t                      src;
    logic [ChanW-1:0]               da;
    logic [ChanW-1:0]               alpha;
    logic [NumChan-1:0][ChanW-1:0]  rem;
    logic [NumChan-1:0][NumW-1:0]   quo;
  } div_t;

endpackage

// ===== hdl/pab_in_if.sv =====
// Input channel of the blend: one source and one destination BGRA pixel per item.
// Depends on pab_pkg for the channel width.
interface pab_in_if;
  logic                      valid;
  logic                      ready;
  logic [pab_pkg::ChanW-1:0] src_blue;
  logic [pab_pkg::ChanW-1:0] src_green;
  logic [pab_pkg::ChanW-1:0] src_red;
  logic [pab_pkg::ChanW-1:0] src_alpha;
  logic [pab_pkg::ChanW-1:0] dst_blue;
  logic [pab_pkg::ChanW-1:0] dst_green;
  logic [pab_pkg::ChanW-1:0] dst_red;
  logic [pab_pkg::ChanW-1:0] dst_alpha;

  modport source (
    output valid, src_blue, src_green, src_red, src_alpha,
           dst_blue, dst_green, dst_red, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_blue, src_green, src_red, src_alpha,
           dst_blue, dst_green, dst_red, dst_alpha,
    output ready
  );
endinterface

// ===== hdl/pab_out_if.sv =====
// Output channel of the blend: one composited BGRA pixel per item.
// Depends on pab_pkg for the channel width.
interface pab_out_if;
  logic                      valid;
  logic                      ready;
  logic [pab_pkg::ChanW-1:0] out_blue;
  logic [pab_pkg::ChanW-1:0] out_green;
  logic [pab_pkg::ChanW-1:0] out_red;
  logic [pab_pkg::ChanW-1:0] out_alpha;

  modport source (
    output valid, out_blue, out_green, out_red, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, out_alpha,
    output ready
  );
endinterface

// ===== hdl/pab_front.sv =====
// First pipeline stage: alpha clamp, new alpha, and dividend products.
// Depends on pab_pkg.
module pab_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pab_pkg::chan_vec_t  src_i,
  input  logic [pab_pkg::ChanW-1:0] src_alpha_i,
  input  pab_pkg::chan_vec_t  dst_i,
  input  logic [pab_pkg::ChanW-1:0] dst_alpha_i,
  output logic                valid_o,
  output pab_pkg::div_t       div_o
);

  logic                        valid_q;
  pab_pkg::div_t               div_d, div_q;
  logic [pab_pkg::ChanW-1:0]   da, inv_sa, amax;
  logic [pab_pkg::NumW-1:0]    asum_prod;
  logic [pab_pkg::ChanW:0]     asum;

  always_comb begin
    da        = (dst_alpha_i == '0) ? pab_pkg::MinAlpha : dst_alpha_i;
    inv_sa    = pab_pkg::FullScale - src_alpha_i;
    amax      = (da > src_alpha_i) ? da : src_alpha_i;
    asum_prod = {{pab_pkg::ChanW{1'b0}}, da} * {{pab_pkg::ChanW{1'b0}}, src_alpha_i};
    asum      = {1'b0, amax} + {1'b0, asum_prod[pab_pkg::NumW-1:pab_pkg::ChanW]};

    div_d.src   = src_i;
    div_d.da    = da;
    div_d.alpha = asum[pab_pkg::ChanW] ? pab_pkg::FullScale : asum[pab_pkg::ChanW-1:0];
    for (int c = 0; c < pab_pkg::NumChan; c++) begin
      div_d.rem[c] = '0;
      div_d.quo[c] = {{pab_pkg::ChanW{1'b0}}, dst_i[c]}
                   * {{pab_pkg::ChanW{1'b0}}, inv_sa};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== hdl/pab_div_stage.sv =====
// One slice of the pipelined restoring divider: a few quotient bits per stage,
// for all color channels in parallel. Depends on pab_pkg.
module pab_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pab_pkg::div_t div_i,
  output logic          valid_o,
  output pab_pkg::div_t div_o
);

  logic          valid_q;
  pab_pkg::div_t div_d, div_q;

  // quo shifts dividend bits out of the top and quotient bits in at the bottom
  always_comb begin
    logic [pab_pkg::ChanW:0] trial;
    logic                    qbit;
    div_d = div_i;
    for (int s = 0; s < pab_pkg::DivStepsPerStg; s++) begin
      for (int c = 0; c < pab_pkg::NumChan; c++) begin
        trial = {div_d.rem[c], div_d.quo[c][pab_pkg::NumW-1]};
        qbit  = (trial >= {1'b0, div_d.da});
        if (qbit) begin
          trial = trial - {1'b0, div_d.da};
        end
        div_d.rem[c] = trial[pab_pkg::ChanW-1:0];
        div_d.quo[c] = {div_d.quo[c][pab_pkg::NumW-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== hdl/pab_back.sv =====
// Last pipeline stage: adds source color to quotient, scales by new alpha,
// and holds the output register. Depends on pab_pkg.
module pab_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  pab_pkg::div_t              div_i,
  output logic                       valid_o,
  output pab_pkg::chan_vec_t         color_o,
  output logic [pab_pkg::ChanW-1:0]  alpha_o
);

  logic                             valid_q;
  pab_pkg::chan_vec_t               color_d, color_q;
  logic [pab_pkg::ChanW-1:0]        alpha_q;
  logic [pab_pkg::NumW-1:0]         csum;
  logic [pab_pkg::NumW+pab_pkg::ChanW-1:0] prod;

  // csum tops out at 65280, so 16 bits hold it; only bits [15:8] of the product survive
  always_comb begin
    csum = '0;
    prod = '0;
    for (int c = 0; c < pab_pkg::NumChan; c++) begin
      csum = div_i.quo[c] + {{pab_pkg::ChanW{1'b0}}, div_i.src[c]};
      prod = {{pab_pkg::ChanW{1'b0}}, csum}
           * {{pab_pkg::NumW{1'b0}}, div_i.alpha};
      color_d[c] = prod[pab_pkg::NumW-1:pab_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      color_q <= color_d;
      alpha_q <= div_i.alpha;
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;
  assign alpha_o = alpha_q;

endmodule

// ===== hdl/premultiplied_alpha_pixel_blend.sv =====
// Premultiplied alpha "over" blend, one BGRA pixel pair per item.
// Throughput: one item per cycle unless out_o.ready stalls the pipeline; the 16-bit
// restoring division runs over 4 stages of 4 quotient bits each, with one stage for
// setup and one for scaling.
// Each stage stalls only when it is full and the one after it is stalled.
// Reset clears all stage valid bits; payload registers are not reset.
module premultiplied_alpha_pixel_blend (
  input  logic      clk_i,
  input  logic      rst_ni,
  pab_in_if.sink    in_i,
  pab_out_if.source out_o
);

  logic [pab_pkg::NumStg-1:0] stg_v;
  logic [pab_pkg::NumStg-1:0] stg_rdy;
  pab_pkg::div_t              div_s [pab_pkg::DivStages+1];
  pab_pkg::chan_vec_t         src_vec, dst_vec, color;
  logic [pab_pkg::ChanW-1:0]  alpha;

  assign src_vec = {in_i.src_red, in_i.src_green, in_i.src_blue};
  assign dst_vec = {in_i.dst_red, in_i.dst_green, in_i.dst_blue};

  // a stage may load when empty or when its successor moves
  always_comb begin
    stg_rdy[pab_pkg::NumStg-1] = !stg_v[pab_pkg::NumStg-1] || out_o.ready;
    for (int k = pab_pkg::NumStg - 2; k >= 0; k--) begin
      stg_rdy[k] = !stg_v[k] || stg_rdy[k+1];
    end
  end

  assign in_i.ready = stg_rdy[0];

  pab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (stg_rdy[0]),
    .valid_i     (in_i.valid),
    .src_i       (src_vec),
    .src_alpha_i (in_i.src_alpha),
    .dst_i       (dst_vec),
    .dst_alpha_i (in_i.dst_alpha),
    .valid_o     (stg_v[0]),
    .div_o       (div_s[0])
  );

  for (genvar k = 0; k < pab_pkg::DivStages; k++) begin : g_div
    pab_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (stg_rdy[k+1]),
      .valid_i (stg_v[k]),
      .div_i   (div_s[k]),
      .valid_o (stg_v[k+1]),
      .div_o   (div_s[k+1])
    );
  end

  pab_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stg_rdy[pab_pkg::NumStg-1]),
    .valid_i (stg_v[pab_pkg::NumStg-2]),
    .div_i   (div_s[pab_pkg::DivStages]),
    .valid_o (stg_v[pab_pkg::NumStg-1]),
    .color_o (color),
    .alpha_o (alpha)
  );

  assign out_o.valid     = stg_v[pab_pkg::NumStg-1];
  assign out_o.out_blue  = color[0];
  assign out_o.out_green = color[1];
  assign out_o.out_red   = color[2];
  assign out_o.out_alpha = alpha;

  // input is refused only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&stg_v))
    else $error("input stalled with a bubble in the pipeline");

  // clamped destination alpha keeps the new alpha at least 1
  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.out_alpha != '0))
    else $error("zero alpha on output");

  a_alpha_ge_da: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v[0] |-> (div_s[0].alpha >= div_s[0].da))
    else $error("new alpha below destination alpha");

  // restoring division leaves every remainder below the divisor
  a_rem_below_da: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v[pab_pkg::DivStages] |->
      (div_s[pab_pkg::DivStages].rem[0] < div_s[pab_pkg::DivStages].da) &&
      (div_s[pab_pkg::DivStages].rem[1] < div_s[pab_pkg::DivStages].da) &&
      (div_s[pab_pkg::DivStages].rem[2] < div_s[pab_pkg::DivStages].da))
    else $error("divider remainder out of range");

endmodule
